[design/token_expiry_table_unit_defines.svh]
// ----------------------------------------------------------------------------
// Token expiry table: assertion macros
// Concurrent assertion helpers used by the table's RTL.
// ----------------------------------------------------------------------------
`ifndef TOKEN_EXPIRY_TABLE_UNIT_DEFINES_SVH
`define TOKEN_EXPIRY_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is asserted
`define TET_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, active through reset as well
`define TET_ASSERT_NR(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TET_ASSERT(name, clk, rst_n, prop, msg)
`define TET_ASSERT_NR(name, clk, prop, msg)

`endif

`endif

[design/tet_pkg.sv]
// ----------------------------------------------------------------------------
// Token expiry table package
// Sizes, request codes, sequencer states and shared structures.
// ----------------------------------------------------------------------------
package tet_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int KIND_W  = 2;
	localparam int KEY_W   = 25;
	localparam int TIME_W  = 31;
	localparam int EXP_W   = 32;
	localparam int LIVE_W  = 7;

	// Request kinds; any other code only counts
	localparam logic [KIND_W-1:0] KIND_GENERATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RENEW    = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [EXP_W-1:0] expiry;
	} entry_t;

	typedef struct packed {
		logic              match_found;
		logic [IDX_W-1:0]  match_idx;
		logic              free_found;
		logic [IDX_W-1:0]  free_idx;
		logic [LIVE_W-1:0] live;
	} scan_result_t;

endpackage

[design/token_expiry_table_unit.sv]
// ----------------------------------------------------------------------------
// Token expiry table unit
// Session key table with time-to-live aging, served by a sweeping sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request
// sweeps the key/expiry memory one entry per cycle through its single
// read port, then drains the read register and then writes back. The
// result then stands on live_count, renew_done and table_full for exactly
// one cycle with done high; the receiver cannot stall, so it must take the
// result in that cycle. busy is already low in that cycle, so the next
// request may start there. The time_to_live register may be written only
// while busy is low and no result is pending; it resets to 1. No clearing
// pass is needed after reset: entry valid bits are held in flip-flops.
// ----------------------------------------------------------------------------
module token_expiry_table_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tet_pkg::KIND_W-1:0]  kind,
	input  logic [tet_pkg::KEY_W-1:0]   token_key,
	input  logic [tet_pkg::TIME_W-1:0]  current_time,
	input  logic                        time_to_live_we,
	input  logic [tet_pkg::TIME_W-1:0]  time_to_live,
	output logic                        done,
	output logic [tet_pkg::LIVE_W-1:0]  live_count,
	output logic                        renew_done,
	output logic                        table_full
);
	import tet_pkg::*;

`include "token_expiry_table_unit_defines.svh"

	state_t state_q, state_d;

	logic [TIME_W-1:0]      ttl_q;
	logic [KIND_W-1:0]      kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [TIME_W-1:0]      time_q;
	logic [EXP_W-1:0]       expiry_q;
	logic [IDX_W-1:0]       rd_ptr_q;
	logic                   eval_vld_s1;
	logic [IDX_W-1:0]       eval_idx_s1;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic         accept;
	logic         scan_en;
	logic         commit;
	logic         last_rd;
	logic         evict;
	logic         do_insert;
	logic         do_update;
	logic         wr_en;
	logic [IDX_W-1:0] wr_idx;
	entry_t       wr_data;
	entry_t       rd_data_s1;
	scan_result_t scan_res;

	logic              done_q;
	logic [LIVE_W-1:0] live_count_q;
	logic              renew_done_q;
	logic              table_full_q;

	assign accept  = start && !busy;
	assign last_rd = (rd_ptr_q == IDX_W'(TABLE_DEPTH - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start)   state_d = ST_SCAN;
			ST_SCAN:   if (last_rd) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy    = 1'b1;
		scan_en = 1'b0;
		commit  = 1'b0;
		unique case (state_q)
			ST_IDLE:   busy    = 1'b0;
			ST_SCAN:   scan_en = 1'b1;
			ST_DRAIN:  ;
			ST_COMMIT: commit  = 1'b1;
			default:   busy    = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the configured lifetime
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TIME_W'(1);
		end else if (time_to_live_we) begin
			ttl_q <= time_to_live;
		end
	end

	// Capture the request transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			key_q    <= token_key;
			time_q   <= current_time;
			expiry_q <= {1'b0, current_time} + {1'b0, ttl_q};
		end
	end

	// Advance the read pointer over the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			eval_vld_s1 <= 1'b0;
			eval_idx_s1 <= '0;
		end else begin
			eval_vld_s1 <= scan_en;
			eval_idx_s1 <= rd_ptr_q;
			if (accept) begin
				rd_ptr_q <= '0;
			end else if (scan_en) begin
				rd_ptr_q <= rd_ptr_q + IDX_W'(1);
			end
		end
	end

	tet_store u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data),
		.rd_idx     (rd_ptr_q),
		.rd_data_s1 (rd_data_s1)
	);

	tet_scan_unit u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (accept),
		.eval_en     (eval_vld_s1),
		.eval_idx    (eval_idx_s1),
		.entry_valid (valid_q[eval_idx_s1]),
		.entry       (rd_data_s1),
		.req_key     (key_q),
		.req_time    (time_q),
		.evict       (evict),
		.result      (scan_res)
	);

	// Decide the write-back
	always_comb begin
		do_update = 1'b0;
		do_insert = 1'b0;
		if (commit) begin
			if (kind_q == KIND_GENERATE) begin
				do_update = scan_res.match_found;
				do_insert = !scan_res.match_found && scan_res.free_found;
			end else if (kind_q == KIND_RENEW) begin
				do_update = scan_res.match_found;
			end
		end
		wr_en          = do_update || do_insert;
		wr_idx         = do_insert ? scan_res.free_idx : scan_res.match_idx;
		wr_data.key    = key_q;
		wr_data.expiry = expiry_q;
	end

	// Drop expired entries, mark inserted ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (evict) begin
				valid_q[eval_idx_s1] <= 1'b0;
			end
			if (do_insert) begin
				valid_q[scan_res.free_idx] <= 1'b1;
			end
		end
	end

	// Register the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= commit;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			live_count_q <= scan_res.live + LIVE_W'(do_insert);
			renew_done_q <= (kind_q == KIND_RENEW) && scan_res.match_found;
			table_full_q <= (kind_q == KIND_GENERATE) && !scan_res.match_found
				&& !scan_res.free_found;
		end
	end

	assign done       = done_q;
	assign live_count = live_count_q;
	assign renew_done = renew_done_q;
	assign table_full = table_full_q;

	// Checks
	`TET_ASSERT(a_done_follows_commit, clk, arst_n, done |-> $past(state_q == ST_COMMIT), "result without write-back")
	`TET_ASSERT(a_accept_goes_busy, clk, arst_n, (start && !busy) |=> busy, "request accepted but sequencer idle")
	`TET_ASSERT(a_full_means_all_live, clk, arst_n, (done && table_full) |-> (live_count == LIVE_W'(TABLE_DEPTH)), "table full reported with free slots")
	`TET_ASSERT(a_idle_on_done, clk, arst_n, !done || !busy, "result shown while still busy")

endmodule

[design/tet_store.sv]
// ----------------------------------------------------------------------------
// Token expiry table store
// Single write, single read memory of keys and expiry times, registered read.
// ----------------------------------------------------------------------------
module tet_store (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [tet_pkg::IDX_W-1:0] wr_idx,
	input  tet_pkg::entry_t      wr_data,
	input  logic [tet_pkg::IDX_W-1:0] rd_idx,
	output tet_pkg::entry_t      rd_data_s1
);
	import tet_pkg::*;

	entry_t mem_q [TABLE_DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	// Read one entry a cycle
	always_ff @(posedge clk) begin
		rd_data_s1 <= mem_q[rd_idx];
	end

endmodule

[design/tet_scan_unit.sv]
// ----------------------------------------------------------------------------
// Token expiry table scan unit
// Examines one entry per cycle while eval_en is high: expiry compare, key
// match, first free slot and live count, accumulated over a table sweep.
// ----------------------------------------------------------------------------
module tet_scan_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        eval_en,
	input  logic [tet_pkg::IDX_W-1:0]   eval_idx,
	input  logic                        entry_valid,
	input  tet_pkg::entry_t             entry,
	input  logic [tet_pkg::KEY_W-1:0]   req_key,
	input  logic [tet_pkg::TIME_W-1:0]  req_time,
	output logic                        evict,
	output tet_pkg::scan_result_t       result
);
	import tet_pkg::*;

	logic         entry_live;
	scan_result_t acc_q;

	// Entry survives if its expiry lies after the request time
	always_comb begin
		entry_live = entry_valid && (entry.expiry > {1'b0, req_time});
		evict      = eval_en && entry_valid && !entry_live;
	end

	// Accumulate match, free slot and live count over the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (eval_en) begin
			if (entry_live) begin
				acc_q.live <= acc_q.live + LIVE_W'(1);
				if (!acc_q.match_found && (entry.key == req_key)) begin
					acc_q.match_found <= 1'b1;
					acc_q.match_idx   <= eval_idx;
				end
			end else if (!acc_q.free_found) begin
				acc_q.free_found <= 1'b1;
				acc_q.free_idx   <= eval_idx;
			end
		end
	end

	assign result = acc_q;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Token expiry table unit testbench
// Drives session requests through the start/busy handshake and scores every
// result against an in-bench copy of the table. A short directed run touches
// field extremes, each request kind, eviction and backward time. Random
// phases at several lifetimes then churn, overwrite and fill the table,
// with the sender idling more in some phases than in others.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tet_pkg::*;

	// Both of these codes only count live entries
	localparam logic [KIND_W-1:0] KIND_COUNT     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_COUNT_ALT = 2'd3;

	localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
	localparam int                CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now;
	} request_t;

	typedef struct {
		logic [LIVE_W-1:0] live;
		logic              renewed;
		logic              dropped;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [KIND_W-1:0]   kind = '0;
	logic [KEY_W-1:0]    token_key = '0;
	logic [TIME_W-1:0]   current_time = '0;
	logic                time_to_live_we = 1'b0;
	logic [TIME_W-1:0]   time_to_live = '0;
	logic                done;
	logic [LIVE_W-1:0]   live_count;
	logic                renew_done;
	logic                table_full;

	// Shadow copy of the session table and its lifetime register
	bit                  slot_live [TABLE_DEPTH];
	bit [KEY_W-1:0]      slot_key [TABLE_DEPTH];
	bit [EXP_W-1:0]      slot_expiry [TABLE_DEPTH];
	bit [TIME_W-1:0]     lifetime = TIME_W'(1);

	request_t            queued_requests [$];
	outcome_t            awaited_outcomes [$];
	logic [KEY_W-1:0]    key_pool [$];
	logic [TIME_W-1:0]   time_cursor = '0;
	int                  idle_pct = 0;
	int                  error_count = 0;
	int                  cycle_count = 0;

	token_expiry_table_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.token_key       (token_key),
		.current_time    (current_time),
		.time_to_live_we (time_to_live_we),
		.time_to_live    (time_to_live),
		.done            (done),
		.live_count      (live_count),
		.renew_done      (renew_done),
		.table_full      (table_full)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Age out stale sessions, serve one request and return its outcome
	function automatic outcome_t age_and_serve(request_t req);
		outcome_t         res;
		int               match_idx;
		int               free_idx;
		int               live;
		logic [EXP_W-1:0] expiry;
		res = '{default: '0};
		match_idx = -1;
		free_idx = -1;
		live = 0;
		expiry = {1'b0, req.now} + {1'b0, lifetime};
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (slot_live[i] && slot_expiry[i] <= {1'b0, req.now})
				slot_live[i] = 1'b0;
			if (slot_live[i]) begin
				if (match_idx < 0 && slot_key[i] == req.key)
					match_idx = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (req.kind == KIND_GENERATE) begin
			if (match_idx >= 0) begin
				slot_expiry[match_idx] = expiry;
			end else if (free_idx >= 0) begin
				slot_live[free_idx] = 1'b1;
				slot_key[free_idx] = req.key;
				slot_expiry[free_idx] = expiry;
			end else begin
				res.dropped = 1'b1;
			end
		end else if (req.kind == KIND_RENEW) begin
			if (match_idx >= 0) begin
				slot_expiry[match_idx] = expiry;
				res.renewed = 1'b1;
			end
		end
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_live[i])
				live++;
		res.live = live[LIVE_W-1:0];
		return res;
	endfunction

	// Present queued requests; predict each one as it is taken
	always @(posedge clk) begin : drive_requests
		request_t req;
		logic     raise;
		raise = start;
		if (arst_n && start && !busy) begin
			req = queued_requests[0];
			queued_requests.delete(0);
			awaited_outcomes.push_back(age_and_serve(req));
			raise = 1'b0;
		end
		if (arst_n && !raise && queued_requests.size() != 0 &&
				$urandom_range(99) >= idle_pct)
			raise = 1'b1;
		if (raise) begin
			req = queued_requests[0];
			kind <= req.kind;
			token_key <= req.key;
			current_time <= req.now;
		end
		start <= raise;
	end

	// Score each result strobe against the oldest prediction
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_outcomes.size() == 0) begin
				$error("result with no request outstanding: live_count %0d", live_count);
				error_count++;
			end else begin
				want = awaited_outcomes[0];
				awaited_outcomes.delete(0);
				if (live_count !== want.live) begin
					$error("live_count: expected %0d, got %0d", want.live, live_count);
					error_count++;
				end
				if (renew_done !== want.renewed) begin
					$error("renew_done: expected %0b, got %0b", want.renewed, renew_done);
					error_count++;
				end
				if (table_full !== want.dropped) begin
					$error("table_full: expected %0b, got %0b", want.dropped, table_full);
					error_count++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic push_request(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
			logic [TIME_W-1:0] now);
		queued_requests.push_back('{kind: k, key: key, now: now});
	endtask

	// Hold until every transaction has been taken and answered
	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_requests.size() != 0 || awaited_outcomes.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_lifetime(logic [TIME_W-1:0] value);
		@(posedge clk);
		time_to_live_we <= 1'b1;
		time_to_live <= value;
		lifetime = value;
		@(posedge clk);
		time_to_live_we <= 1'b0;
	endtask

	// Random phase: mostly sessions from a small key pool, plus stray keys
	// and the odd request stamped slightly in the past
	task automatic run_phase(logic [TIME_W-1:0] ttl, int gap_pct, int count,
			int pool_size, int max_step);
		int                roll;
		logic [KIND_W-1:0] k;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now;
		wait_drained();
		write_lifetime(ttl);
		@(negedge clk);
		idle_pct = gap_pct;
		key_pool.delete();
		repeat (pool_size) key_pool.push_back(KEY_W'($urandom()));
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 45)
				k = KIND_GENERATE;
			else if (roll < 80)
				k = KIND_RENEW;
			else if (roll < 90)
				k = KIND_COUNT;
			else
				k = KIND_COUNT_ALT;
			key = key_pool[$urandom_range(pool_size - 1)];
			if ($urandom_range(99) < 10)
				key = KEY_W'($urandom());
			if ($urandom_range(99) < 2)
				time_cursor += TIME_W'($urandom_range(1 << 20));
			else
				time_cursor += TIME_W'($urandom_range(max_step));
			now = time_cursor;
			if ($urandom_range(99) < 3)
				now = time_cursor - TIME_W'($urandom_range(100));
			push_request(k, key, now);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed run at the reset lifetime of one tick
		push_request(KIND_GENERATE, '0, '0);
		push_request(KIND_GENERATE, KEY_MAX, '0);
		push_request(KIND_RENEW, '0, '0);
		push_request(KIND_RENEW, 25'h0ABCDEF, '0);
		push_request(KIND_COUNT, '0, '0);
		push_request(KIND_COUNT_ALT, KEY_MAX, '0);
		push_request(KIND_GENERATE, '0, '0);
		// everything lapses once time reaches its expiry
		push_request(KIND_GENERATE, 25'h1555555, 31'd1);
		push_request(KIND_RENEW, 25'h1555555, 31'd2);
		// expiry past the 31-bit time range, then time running backwards
		push_request(KIND_GENERATE, 25'h0AAAAAA, TIME_MAX);
		push_request(KIND_COUNT, '0, 31'd5);
		push_request(KIND_RENEW, 25'h0AAAAAA, 31'd5);
		push_request(KIND_COUNT, '0, 31'd6);
		push_request(KIND_GENERATE, '0, 31'h4000_0000);
		push_request(KIND_COUNT_ALT, '0, 31'h4000_0001);
		time_cursor = 31'h4000_0001;

		run_phase(31'd20, 0, 350, 40, 8);
		run_phase(31'd1, 85, 150, 20, 1);
		run_phase(31'd5000, 23, 300, 100, 30);
		run_phase(31'd300, 85, 200, 60, 20);
		run_phase(31'd60, 0, 350, 30, 6);
		// Longest lifetime last: these sessions never lapse
		run_phase(TIME_MAX, 23, 100, 90, 1000);

		wait_drained();
		repeat (TABLE_DEPTH + 8) @(negedge clk);
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
